>>> hw/rtl/cursor_sequence_buffer_top_defines.svh
// assertion macros for the cursor sequence buffer rtl, used by csb_datapath
// expects clk and rst in the scope where the macros are used
`ifndef CURSOR_SEQUENCE_BUFFER_TOP_DEFINES_SVH
`define CURSOR_SEQUENCE_BUFFER_TOP_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define CSB_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition that must hold whenever a trigger is seen
`define CSB_ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

>>> hw/rtl/csb_pkg.sv
// package for the cursor sequence buffer: opcodes, controller states and
// the command/status structs between controller and datapath; no dependencies
package csb_pkg;

  typedef enum logic [2:0] {
    OP_QUERY   = 3'd0,
    OP_START   = 3'd1,
    OP_ADVANCE = 3'd2,
    OP_INSERT  = 3'd3,
    OP_ATTACH  = 3'd4,
    OP_REMOVE  = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT_UP,
    ST_PLACE,
    ST_SHIFT_DN,
    ST_SHRINK,
    ST_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic do_start;
    logic do_advance;
    logic set_refused;
    logic setup_up;
    logic up_step;
    logic place;
    logic setup_dn;
    logic dn_step;
    logic shrink;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    has_cur;
    logic    full;
    logic    need_up;
    logic    more_up;
    logic    need_dn;
    logic    more_dn;
    logic    out_free;
  } status_t;

endpackage

>>> hw/rtl/csb_ifs.sv
// valid/ready channel interfaces for the cursor sequence buffer
// request carries one operation, response carries one result; no dependencies
interface csb_in_if #(
  parameter int VW = 32
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           opcode;
  logic signed [VW-1:0] entry_value;

  modport source (output valid, output opcode, output entry_value, input ready);
  modport sink   (input valid, input opcode, input entry_value, output ready);
endinterface

interface csb_out_if #(
  parameter int VW = 32,
  parameter int CW = 7
);
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] current_value;
  logic                 current_valid;
  logic [CW-1:0]        entry_count;
  logic                 overflow_flag;

  modport source (output valid, output current_value, output current_valid,
                  output entry_count, output overflow_flag, input ready);
  modport sink   (input valid, input current_value, input current_valid,
                  input entry_count, input overflow_flag, output ready);
endinterface

>>> hw/rtl/csb_ctrl.sv
// controller state machine for the cursor sequence buffer
// depends on csb_pkg for states, opcodes and the command/status structs
module csb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  csb_pkg::status_t status,
  output csb_pkg::cmd_t    cmd
);

  csb_pkg::state_t state;
  csb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      csb_pkg::ST_IDLE: begin
        if (in_valid) state_next = csb_pkg::ST_EXEC;
      end
      csb_pkg::ST_EXEC: begin
        case (status.op)
          csb_pkg::OP_INSERT, csb_pkg::OP_ATTACH: begin
            if (status.full) state_next = csb_pkg::ST_READ;
            else if (status.need_up) state_next = csb_pkg::ST_SHIFT_UP;
            else state_next = csb_pkg::ST_PLACE;
          end
          csb_pkg::OP_REMOVE: begin
            if (!status.has_cur) state_next = csb_pkg::ST_READ;
            else if (status.need_dn) state_next = csb_pkg::ST_SHIFT_DN;
            else state_next = csb_pkg::ST_SHRINK;
          end
          default: state_next = csb_pkg::ST_READ;
        endcase
      end
      csb_pkg::ST_SHIFT_UP: begin
        if (!status.more_up) state_next = csb_pkg::ST_PLACE;
      end
      csb_pkg::ST_PLACE:  state_next = csb_pkg::ST_READ;
      csb_pkg::ST_SHIFT_DN: begin
        if (!status.more_dn) state_next = csb_pkg::ST_SHRINK;
      end
      csb_pkg::ST_SHRINK: state_next = csb_pkg::ST_READ;
      csb_pkg::ST_READ:   state_next = csb_pkg::ST_OUT;
      csb_pkg::ST_OUT: begin
        if (status.out_free) state_next = csb_pkg::ST_IDLE;
      end
      default: state_next = csb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      csb_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      csb_pkg::ST_EXEC: begin
        case (status.op)
          csb_pkg::OP_START:   cmd.do_start = 1'b1;
          csb_pkg::OP_ADVANCE: cmd.do_advance = status.has_cur;
          csb_pkg::OP_INSERT, csb_pkg::OP_ATTACH: begin
            cmd.set_refused = status.full;
            cmd.setup_up    = !status.full;
          end
          csb_pkg::OP_REMOVE:  cmd.setup_dn = status.has_cur;
          default: ;
        endcase
      end
      csb_pkg::ST_SHIFT_UP: cmd.up_step = 1'b1;
      csb_pkg::ST_PLACE:    cmd.place = 1'b1;
      csb_pkg::ST_SHIFT_DN: cmd.dn_step = 1'b1;
      csb_pkg::ST_SHRINK:   cmd.shrink = 1'b1;
      csb_pkg::ST_OUT:      cmd.load_out = status.out_free;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/csb_datapath.sv
// datapath: entry memory, count, cursor, shift index and the result register
// depends on csb_pkg and on cursor_sequence_buffer_top_defines.svh
`include "cursor_sequence_buffer_top_defines.svh"

module csb_datapath #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32,
  parameter int CW          = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  csb_pkg::cmd_t                 cmd,
  output csb_pkg::status_t              status,
  input  logic [2:0]                    in_opcode,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_value,
  output logic                          out_cur_valid,
  output logic [CW-1:0]                 out_count,
  output logic                          out_refused
);

  localparam int AW = $clog2(CAPACITY);

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] rdata;
  logic [VALUE_WIDTH-1:0] value_r;
  csb_pkg::opcode_t       opcode_r;
  logic [CW-1:0]          count;
  logic [CW-1:0]          cursor;
  logic [CW-1:0]          idx;
  logic [CW-1:0]          pos;
  logic                   refused;

  logic                   has_cur;
  logic                   full;
  logic [CW-1:0]          pos_calc;
  logic [CW-1:0]          rd_addr;
  logic                   wr_en;
  logic [CW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  assign has_cur = cursor < count;
  assign full    = count == CW'(CAPACITY);

  always_comb begin
    if (opcode_r == csb_pkg::OP_ATTACH) begin
      pos_calc = has_cur ? cursor + CW'(1) : count;
    end else begin
      pos_calc = has_cur ? cursor : '0;
    end
  end

  always_comb begin
    status.op       = opcode_r;
    status.has_cur  = has_cur;
    status.full     = full;
    status.need_up  = count > pos_calc;
    status.more_up  = (idx - CW'(1)) > pos;
    status.need_dn  = ({1'b0, cursor} + (CW+1)'(1)) < {1'b0, count};
    status.more_dn  = ({1'b0, idx} + (CW+1)'(2)) < {1'b0, count};
    status.out_free = !out_valid || out_ready;
  end

  // read one ahead of the write so a shift moves one entry per cycle
  always_comb begin
    if (cmd.setup_up)      rd_addr = count - CW'(1);
    else if (cmd.up_step)  rd_addr = idx - CW'(2);
    else if (cmd.setup_dn) rd_addr = cursor + CW'(1);
    else if (cmd.dn_step)  rd_addr = idx + CW'(2);
    else                   rd_addr = cursor;
  end

  always_comb begin
    wr_en   = cmd.up_step || cmd.dn_step || cmd.place;
    wr_addr = cmd.place ? pos : idx;
    wr_data = cmd.place ? value_r : rdata;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    rdata <= mem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      value_r <= in_value;
    end
    if (cmd.setup_up) begin
      pos <= pos_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      opcode_r <= csb_pkg::OP_QUERY;
      count    <= '0;
      cursor   <= '0;
      idx      <= '0;
      refused  <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        opcode_r <= csb_pkg::opcode_t'(in_opcode);
        refused  <= 1'b0;
      end
      if (cmd.set_refused) refused <= 1'b1;
      if (cmd.do_start) cursor <= '0;
      if (cmd.do_advance) cursor <= cursor + CW'(1);
      if (cmd.setup_up) idx <= count;
      if (cmd.up_step) idx <= idx - CW'(1);
      if (cmd.setup_dn) idx <= cursor;
      if (cmd.dn_step) idx <= idx + CW'(1);
      if (cmd.place) begin
        count  <= count + CW'(1);
        cursor <= pos;
      end
      if (cmd.shrink) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value     <= has_cur ? rdata : '0;
      out_cur_valid <= has_cur;
      out_count     <= count;
      out_refused   <= refused;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `CSB_ASSERT_ALWAYS(a_cursor_le_count, cursor <= count, "cursor beyond entry count")
  `CSB_ASSERT_ALWAYS(a_count_le_cap, count <= CW'(CAPACITY), "entry count beyond capacity")
  `CSB_ASSERT_IMPLY(a_place_has_room, cmd.place, !full, "place into a full store")
  `CSB_ASSERT_IMPLY(a_shrink_not_empty, cmd.shrink, count != '0, "shrink of an empty store")
  `CSB_ASSERT_IMPLY(a_up_above_pos, cmd.up_step, idx > pos, "upward shift below insert slot")

endmodule

>>> hw/rtl/cursor_sequence_buffer_top.sv
// cursor sequence buffer: one operation in, one result out, one at a time
// after acceptance: exec, then read, then out, which waits for the output to be free;
// insert and attach, unless refused, add shift-up steps and a place step before read,
// remove with a cursor adds shift-down steps and shrink; up to CAPACITY - 1 entries shift
// rst (synchronous) empties the store and zeroes the cursor; entry memory is not cleared
module cursor_sequence_buffer_top #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  csb_in_if.sink     req,
  csb_out_if.source  rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  csb_pkg::cmd_t    cmd;
  csb_pkg::status_t status;

  csb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  csb_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .CW          (CW)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_opcode     (req.opcode),
    .in_value      (req.entry_value),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_value     (rsp.current_value),
    .out_cur_valid (rsp.current_valid),
    .out_count     (rsp.entry_count),
    .out_refused   (rsp.overflow_flag)
  );

endmodule

>>> bench/tb_top.sv
// self-checking bench for cursor_sequence_buffer_top: a directed table, then random
// fill and drain traffic checked against a shadow sequence; needs csb_pkg and csb_ifs
`timescale 1ns / 100ps

module tb_top;

  localparam int CAPACITY       = 64;
  localparam int VALUE_WIDTH    = 32;
  localparam int RANDOM_ITEMS   = 1425;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRINT_LIMIT    = 40;

  // opcodes the block treats as a query
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] current_value;
    logic                          current_valid;
    logic [6:0]                    entry_count;
    logic                          overflow_flag;
  } seq_view_t;

  typedef struct packed {
    logic [2:0]                    op;
    logic signed [VALUE_WIDTH-1:0] value;
    bit                            typed;
    seq_view_t                     want;
  } directed_row_t;

  localparam seq_view_t VIEW_EMPTY = '0;
  localparam int DIRECTED_ROWS = 25;

  localparam directed_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
    '{csb_pkg::OP_QUERY,   32'sd0,        1'b1, VIEW_EMPTY},
    '{csb_pkg::OP_REMOVE,  32'sd0,        1'b1, VIEW_EMPTY},
    '{csb_pkg::OP_ADVANCE, 32'sd0,        1'b1, VIEW_EMPTY},
    '{csb_pkg::OP_START,   32'sd0,        1'b1, VIEW_EMPTY},
    '{OP_SPARE_6,          32'sh12345678, 1'b1, VIEW_EMPTY},
    '{OP_SPARE_7,          -32'sd1,       1'b1, VIEW_EMPTY},
    '{csb_pkg::OP_INSERT,  32'sh7FFFFFFF, 1'b1, '{32'sh7FFFFFFF, 1'b1, 7'd1, 1'b0}},
    '{csb_pkg::OP_ATTACH,  32'sh80000000, 1'b1, '{32'sh80000000, 1'b1, 7'd2, 1'b0}},
    '{csb_pkg::OP_START,   32'sd0,        1'b0, VIEW_EMPTY},
    '{csb_pkg::OP_INSERT,  -32'sd1,       1'b0, VIEW_EMPTY},
    '{csb_pkg::OP_ADVANCE, 32'sd0,        1'b0, VIEW_EMPTY},
    '{csb_pkg::OP_ADVANCE, 32'sd0,        1'b0, VIEW_EMPTY},
    '{csb_pkg::OP_ADVANCE, 32'sd0,        1'b0, VIEW_EMPTY},
    '{csb_pkg::OP_ADVANCE, 32'sd0,        1'b0, VIEW_EMPTY},
    '{csb_pkg::OP_ATTACH,  32'sd0,        1'b0, VIEW_EMPTY},
    '{csb_pkg::OP_ADVANCE, 32'sd0,        1'b0, VIEW_EMPTY},
    '{csb_pkg::OP_INSERT,  32'sd1,        1'b0, VIEW_EMPTY},
    '{csb_pkg::OP_REMOVE,  32'sh55AA55AA, 1'b0, VIEW_EMPTY},
    '{csb_pkg::OP_ADVANCE, 32'sd0,        1'b0, VIEW_EMPTY},
    '{csb_pkg::OP_REMOVE,  32'sd0,        1'b0, VIEW_EMPTY},
    '{csb_pkg::OP_START,   32'sd0,        1'b0, VIEW_EMPTY},
    '{csb_pkg::OP_REMOVE,  32'sd0,        1'b0, VIEW_EMPTY},
    '{csb_pkg::OP_REMOVE,  32'sd0,        1'b0, VIEW_EMPTY},
    '{csb_pkg::OP_REMOVE,  32'sd0,        1'b0, VIEW_EMPTY},
    '{csb_pkg::OP_QUERY,   32'sd0,        1'b1, VIEW_EMPTY}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  csb_in_if  #(.VW(VALUE_WIDTH))           req_if ();
  csb_out_if #(.VW(VALUE_WIDTH), .CW(7))   rsp_if ();

  cursor_sequence_buffer_top #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #5 clk = ~clk;

  // shadow of the ordered store
  logic signed [VALUE_WIDTH-1:0] shadow_entries [CAPACITY];
  int shadow_count  = 0;
  int shadow_cursor = 0;

  seq_view_t pending_views [$];

  int error_count     = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int refused_total   = 0;
  int peak_fill       = 0;
  int send_calm       = 0;
  int take_calm       = 0;
  int idle_cycles     = 0;

  function automatic seq_view_t step_shadow_sequence(input logic [2:0] op,
                                                     input logic signed [VALUE_WIDTH-1:0] val);
    int        i;
    int        pos;
    bit        has_cur;
    seq_view_t view;
    view    = '0;
    has_cur = shadow_cursor < shadow_count;
    case (op)
      csb_pkg::OP_START: begin
        shadow_cursor = 0;
      end
      csb_pkg::OP_ADVANCE: begin
        if (has_cur) shadow_cursor++;
      end
      csb_pkg::OP_INSERT, csb_pkg::OP_ATTACH: begin
        if (shadow_count >= CAPACITY) begin
          view.overflow_flag = 1'b1;
        end else begin
          if (op == csb_pkg::OP_INSERT) pos = has_cur ? shadow_cursor : 0;
          else                          pos = has_cur ? shadow_cursor + 1 : shadow_count;
          for (i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[pos] = val;
          shadow_count++;
          shadow_cursor = pos;
        end
      end
      csb_pkg::OP_REMOVE: begin
        if (has_cur) begin
          for (i = shadow_cursor; i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      default: begin
      end
    endcase
    if (shadow_cursor < shadow_count) begin
      view.current_value = shadow_entries[shadow_cursor];
      view.current_valid = 1'b1;
    end
    view.entry_count = shadow_count[6:0];
    return view;
  endfunction

  // wait before the next transfer, with occasional runs of back-to-back ones
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [2:0] pick_op(input bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 35)      return csb_pkg::OP_INSERT;
      else if (r < 70) return csb_pkg::OP_ATTACH;
      else if (r < 78) return csb_pkg::OP_START;
      else if (r < 88) return csb_pkg::OP_ADVANCE;
      else if (r < 93) return csb_pkg::OP_REMOVE;
      else if (r < 97) return csb_pkg::OP_QUERY;
      else if (r < 98) return OP_SPARE_6;
      else             return OP_SPARE_7;
    end
    if (r < 45)      return csb_pkg::OP_REMOVE;
    else if (r < 60) return csb_pkg::OP_ADVANCE;
    else if (r < 75) return csb_pkg::OP_START;
    else if (r < 83) return csb_pkg::OP_INSERT;
    else if (r < 91) return csb_pkg::OP_ATTACH;
    else if (r < 96) return csb_pkg::OP_QUERY;
    else if (r < 98) return OP_SPARE_6;
    else             return OP_SPARE_7;
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return 32'sh7FFFFFFF;
      3:       return 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < PRINT_LIMIT)
      $display("%0t mismatch on %s at result %0d: got %0h, expected %0h",
               $time, what, results_checked, got, want);
    error_count++;
  endtask

  task automatic push_item(input logic [2:0] op, input logic signed [VALUE_WIDTH-1:0] val,
                           input bit typed, input seq_view_t want);
    int        gap;
    seq_view_t view;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= op;
    req_if.entry_value <= val;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    // transfer at this edge
    view = step_shadow_sequence(op, val);
    pending_views.push_back(typed ? want : view);
    items_sent++;
    if (view.overflow_flag) refused_total++;
    if (shadow_count > peak_fill) peak_fill = shadow_count;
  endtask

  // sender
  initial begin
    bit filling;
    int n;
    req_if.valid       = 1'b0;
    req_if.opcode      = csb_pkg::OP_QUERY;
    req_if.entry_value = '0;
    filling            = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < DIRECTED_ROWS; n++)
      push_item(DIRECTED_TABLE[n].op, DIRECTED_TABLE[n].value,
                DIRECTED_TABLE[n].typed, DIRECTED_TABLE[n].want);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (filling && shadow_count == CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if (!filling && shadow_count == 0) filling = 1'b1;
      else if ($urandom_range(0, 99) == 0) filling = !filling;
      push_item(pick_op(filling), pick_value(), 1'b0, VIEW_EMPTY);
    end
    req_if.valid <= 1'b0;

    while (pending_views.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d operations with %0d results checked", items_sent, results_checked);
    $display("store filled to %0d of %0d, %0d writes refused when full",
             peak_fill, CAPACITY, refused_total);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // receiver, with one long hold-off so the block backs up onto its input
  initial begin
    int  stall;
    int  results_taken;
    bit  held_off;
    rsp_if.ready  = 1'b0;
    results_taken = 0;
    held_off      = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && results_taken >= HOLD_AT) begin
        held_off = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = draw_wait(take_calm);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_if.valid) @(posedge clk);
      results_taken++;
    end
  end

  // checker
  always @(posedge clk) begin
    seq_view_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_views.size() == 0) begin
        report_mismatch("unexpected result", rsp_if.current_value, '0);
      end else begin
        want = pending_views.pop_front();
        if (rsp_if.current_value !== want.current_value)
          report_mismatch("current_value", rsp_if.current_value, want.current_value);
        if (rsp_if.current_valid !== want.current_valid)
          report_mismatch("current_valid", 32'(rsp_if.current_valid),
                          32'(want.current_valid));
        if (rsp_if.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(rsp_if.entry_count), 32'(want.entry_count));
        if (rsp_if.overflow_flag !== want.overflow_flag)
          report_mismatch("overflow_flag", 32'(rsp_if.overflow_flag),
                          32'(want.overflow_flag));
      end
      results_checked++;
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending_views.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
